@@ hdl/cbad_pkg.sv @@
// Shared types and constants for the compass packed-decimal angle decoder.
// No dependencies; imported by every module of the block.
package cbad_pkg;

  localparam int unsigned BCD_W     = 24;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned ANGLE_W   = 22;
  localparam int unsigned HEADING_W = 21;
  localparam int unsigned TILT_W    = 16;
  localparam int unsigned TILT_MAG_W = 15;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 21;
  localparam int unsigned NUM_DIGITS = 6;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_HEADING = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ROLL    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PITCH   = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HEADING_JUMP_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEADING_JUMP_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TILT_JUMP_LOW     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TILT_JUMP_HIGH    = 2'd3;

  // Register reset values
  localparam logic [HEADING_W-1:0] HEADING_JUMP_LOW_RST  = 21'd1500;
  localparam logic [HEADING_W-1:0] HEADING_JUMP_HIGH_RST = 21'd20000;
  localparam logic [TILT_W-1:0]    TILT_JUMP_LOW_RST     = 16'd500;
  localparam logic [TILT_W-1:0]    TILT_JUMP_HIGH_RST    = 16'd8000;

  // Decimal weight of each nibble, most significant nibble first
  localparam logic [HEADING_W-1:0] DIGIT_WEIGHT [NUM_DIGITS] = '{
    21'd100000, 21'd10000, 21'd1000, 21'd100, 21'd10, 21'd1
  };

  typedef struct packed {
    logic [HEADING_W-1:0] heading_lo;
    logic [HEADING_W-1:0] heading_hi;
    logic [TILT_W-1:0]    tilt_lo;
    logic [TILT_W-1:0]    tilt_hi;
  } cbad_limits_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle;
    logic                      held;
  } cbad_result_t;

endpackage

@@ hdl/cbad_decode.sv @@
// Packed-decimal to binary weighting of one reading word.
// Depends on cbad_pkg for widths, weights and command codes.
module cbad_decode (
  input  logic [cbad_pkg::CMD_W-1:0]          cmd,
  input  logic [cbad_pkg::BCD_W-1:0]          bcd,
  output logic signed [cbad_pkg::ANGLE_W-1:0] value
);
  import cbad_pkg::*;

  logic [HEADING_W-1:0]  heading_val;
  logic [TILT_MAG_W-1:0] tilt_mag;
  logic                  tilt_neg;

  // Nibbles above nine keep their binary value and are weighted like any digit.
  always_comb begin
    heading_val = '0;
    for (int k = 0; k < NUM_DIGITS; k++) begin
      heading_val = heading_val +
        HEADING_W'(21'(bcd[BCD_W-1-4*k -: 4]) * DIGIT_WEIGHT[k]);
    end
  end

  always_comb begin
    tilt_mag = '0;
    for (int k = 2; k < NUM_DIGITS; k++) begin
      tilt_mag = tilt_mag +
        TILT_MAG_W'(21'(bcd[BCD_W-1-4*k -: 4]) * DIGIT_WEIGHT[k]);
    end
  end

  assign tilt_neg = |bcd[BCD_W-1 -: 8];

  always_comb begin
    if (cmd == CMD_HEADING) begin
      value = signed'({1'b0, heading_val});
    end else if (tilt_neg) begin
      value = -signed'({{(ANGLE_W-TILT_MAG_W){1'b0}}, tilt_mag});
    end else begin
      value = signed'({{(ANGLE_W-TILT_MAG_W){1'b0}}, tilt_mag});
    end
  end

endmodule

@@ hdl/cbad_filter.sv @@
// Per-axis spike filter: holds last value and seen flag of each axis.
// Depends on cbad_pkg for command codes, limits and result types.
module cbad_filter (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                fire,
  input  logic [cbad_pkg::CMD_W-1:0]          cmd,
  input  logic signed [cbad_pkg::ANGLE_W-1:0] value,
  input  cbad_pkg::cbad_limits_t              limits,
  output cbad_pkg::cbad_result_t              result
);
  import cbad_pkg::*;

  logic [HEADING_W-1:0]     last_heading_r;
  logic                     heading_seen_r;
  logic signed [TILT_W-1:0] last_roll_r;
  logic                     roll_seen_r;
  logic signed [TILT_W-1:0] last_pitch_r;
  logic                     pitch_seen_r;

  logic signed [ANGLE_W-1:0] last_sel;
  logic                      seen_sel;
  logic [HEADING_W-1:0]      lo_sel;
  logic [HEADING_W-1:0]      hi_sel;
  logic                      axis_ok;
  logic signed [ANGLE_W:0]   diff;
  logic [ANGLE_W-1:0]        mag;
  logic                      spike;

  always_comb begin
    last_sel = '0;
    seen_sel = 1'b0;
    lo_sel   = '0;
    hi_sel   = '0;
    axis_ok  = 1'b1;
    unique case (cmd)
      CMD_HEADING: begin
        last_sel = signed'({1'b0, last_heading_r});
        seen_sel = heading_seen_r;
        lo_sel   = limits.heading_lo;
        hi_sel   = limits.heading_hi;
      end
      CMD_ROLL: begin
        last_sel = ANGLE_W'(last_roll_r);
        seen_sel = roll_seen_r;
        lo_sel   = HEADING_W'(limits.tilt_lo);
        hi_sel   = HEADING_W'(limits.tilt_hi);
      end
      CMD_PITCH: begin
        last_sel = ANGLE_W'(last_pitch_r);
        seen_sel = pitch_seen_r;
        lo_sel   = HEADING_W'(limits.tilt_lo);
        hi_sel   = HEADING_W'(limits.tilt_hi);
      end
      default: axis_ok = 1'b0;
    endcase
  end

  assign diff  = {value[ANGLE_W-1], value} - {last_sel[ANGLE_W-1], last_sel};
  assign mag   = diff[ANGLE_W] ? ANGLE_W'(-diff) : diff[ANGLE_W-1:0];
  assign spike = seen_sel && (mag > {1'b0, lo_sel}) && (mag < {1'b0, hi_sel});

  // Unused command: no state change, zero word out.
  always_comb begin
    if (!axis_ok) begin
      result.angle = '0;
      result.held  = 1'b0;
    end else begin
      result.angle = spike ? last_sel : value;
      result.held  = spike;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_heading_r <= '0;
      heading_seen_r <= 1'b0;
      last_roll_r    <= '0;
      roll_seen_r    <= 1'b0;
      last_pitch_r   <= '0;
      pitch_seen_r   <= 1'b0;
    end else if (fire) begin
      case (cmd)
        CMD_HEADING: begin
          last_heading_r <= result.angle[HEADING_W-1:0];
          heading_seen_r <= 1'b1;
        end
        CMD_ROLL: begin
          last_roll_r <= result.angle[TILT_W-1:0];
          roll_seen_r <= 1'b1;
        end
        CMD_PITCH: begin
          last_pitch_r <= result.angle[TILT_W-1:0];
          pitch_seen_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule

@@ hdl/compass_bcd_angle_decoder_core.sv @@
// Top level of the compass packed-decimal angle decoder with spike rejection.
// Depends on cbad_pkg, cbad_decode and cbad_filter.
//
//  channel | ports                                     | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_stall, in_command, in_reading_bcd | sink
//  out     | out_valid, out_stall, out_angle_hundredths, out_spike_held | source
//  cfg     | cfg_we, cfg_index, cfg_wdata              | sink, write only
//
// One word per cycle sustained while out_stall is low; an accepted word passes
// the input register, then decode and filter into the output register.
// Axis state is read and updated in the same cycle, so words follow back to back.
// rst_n is synchronous: limits return to defaults, all axes forget their last value.
// in_stall rises only while the input register is full and the output word is stalled.
module compass_bcd_angle_decoder_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [cbad_pkg::CMD_W-1:0]           in_command,
  input  logic [cbad_pkg::BCD_W-1:0]           in_reading_bcd,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [cbad_pkg::ANGLE_W-1:0]  out_angle_hundredths,
  output logic                                 out_spike_held,
  input  logic                                 cfg_we,
  input  logic [cbad_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cbad_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import cbad_pkg::*;

  cbad_limits_t limits_r;

  logic                s1_valid_r;
  logic [CMD_W-1:0]    s1_cmd_r;
  logic [BCD_W-1:0]    s1_bcd_r;
  logic                out_valid_r;
  cbad_result_t        out_res_r;

  logic                      advance;
  logic                      in_take;
  logic signed [ANGLE_W-1:0] value;
  cbad_result_t              result;

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limits_r.heading_lo <= HEADING_JUMP_LOW_RST;
      limits_r.heading_hi <= HEADING_JUMP_HIGH_RST;
      limits_r.tilt_lo    <= TILT_JUMP_LOW_RST;
      limits_r.tilt_hi    <= TILT_JUMP_HIGH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HEADING_JUMP_LOW:  limits_r.heading_lo <= cfg_wdata;
        REG_HEADING_JUMP_HIGH: limits_r.heading_hi <= cfg_wdata;
        REG_TILT_JUMP_LOW:     limits_r.tilt_lo    <= cfg_wdata[TILT_W-1:0];
        REG_TILT_JUMP_HIGH:    limits_r.tilt_hi    <= cfg_wdata[TILT_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_cmd_r <= in_command;
      s1_bcd_r <= in_reading_bcd;
    end
  end

  cbad_decode u_decode (
    .cmd   (s1_cmd_r),
    .bcd   (s1_bcd_r),
    .value (value)
  );

  cbad_filter u_filter (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (s1_valid_r && advance),
    .cmd    (s1_cmd_r),
    .value  (value),
    .limits (limits_r),
    .result (result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && advance) begin
      out_res_r <= result;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_angle_hundredths = out_res_r.angle;
  assign out_spike_held       = out_res_r.held;

endmodule

@@ hdl/cbad_checker.sv @@
// Port-level checks for the compass angle decoder, bound to the top level.
// Depends on cbad_pkg and compass_bcd_angle_decoder_core.
module cbad_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [cbad_pkg::ANGLE_W-1:0] out_angle_hundredths,
  input logic                                out_spike_held
);
  import cbad_pkg::*;

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_angle_hundredths)
      && $stable(out_spike_held))
    else $error("output word changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

  // input may only back up behind a stalled output word
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || !out_stall) |-> !in_stall)
    else $error("input stalled while output is free");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_angle_hundredths >= -22'sd16665)
      && (out_angle_hundredths <= 22'sd1666665))
    else $error("angle out of range");

endmodule

bind compass_bcd_angle_decoder_core cbad_checker u_cbad_checker (.*);
